/* hw/rtl/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Types, widths and stage indexes shared by the segment closest-points block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;          // coordinate difference
  localparam int PW   = 2 * DW;          // one coordinate product
  localparam int SW   = PW + 2;          // dot product of three terms
  localparam int HW   = SW / 2;          // low half of a split multiply
  localparam int MW   = 2 * SW;          // product of two dot products
  localparam int NW   = MW + 2;          // numerators and determinant
  localparam int RW   = NW + 1;          // divider remainder
  localparam int QW   = 16;              // fraction bits of a parameter
  localparam int EW   = 32;              // epsilon register
  localparam int PRW  = DW + QW + 3;     // difference times parameter
  localparam int SUMW = PRW - QW + 1;    // start plus scaled difference

  localparam logic [QW:0] PARAM_ONE  = (QW + 1)'(1) << QW;
  localparam int          ROUND_HALF = 1 << (QW - 1);

  // Pipeline stage indexes.
  localparam int ST_CLAMP = 3;
  localparam int ST_DIV   = 8;
  localparam int ST_PNT   = ST_DIV + QW + 1;
  localparam int NST      = ST_PNT + 2;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [QW:0]          frac_t;
  typedef logic signed [NW-1:0] wide_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_start_z;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t first_end_z;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_start_z;
    coord_t second_end_x;
    coord_t second_end_y;
    coord_t second_end_z;
  } in_t;

  typedef struct packed {
    frac_t  param_first;
    frac_t  param_second;
    coord_t near_first_x;
    coord_t near_first_y;
    coord_t near_first_z;
    coord_t near_second_x;
    coord_t near_second_y;
    coord_t near_second_z;
  } out_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } vec_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pnt_t;

  // Start points and directions, carried alongside the arithmetic.
  typedef struct packed {
    pnt_t p0;
    vec_t u;
    pnt_t q0;
    vec_t v;
  } side_t;

  typedef struct packed {
    logic signed [SW-1:0] k;
    logic signed [SW-1:0] j;
    logic signed [SW-1:0] c;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] e;
  } dots_t;

  typedef struct packed {
    wide_t sn;
    wide_t sd;
    wide_t tn;
    wide_t td;
  } ratio_t;

endpackage

/* hw/rtl/ssc_in_if.sv */
// ----------------------------------------------------------------------------
// ssc_in_if
// Input channel: one segment pair per word.
// ----------------------------------------------------------------------------
interface ssc_in_if;
  logic          valid;
  logic          ready;
  ssc_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ssc_out_if.sv */
// ----------------------------------------------------------------------------
// ssc_out_if
// Result channel: parameters and closest points per word.
// ----------------------------------------------------------------------------
interface ssc_out_if;
  logic          valid;
  logic          ready;
  ssc_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/ssc_cfg_if.sv */
// ----------------------------------------------------------------------------
// ssc_cfg_if
// Configuration write channel carrying the epsilon register value.
// ----------------------------------------------------------------------------
interface ssc_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [ssc_pkg::EW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/segment_segment_closest_points_unit.sv */
// ----------------------------------------------------------------------------
// segment_segment_closest_points_unit
// Closest points between two 3D segments, fully pipelined.
// ----------------------------------------------------------------------------
// Each word on in_ch carries the endpoints of two segments in signed Q8.8.
// Each word on out_ch carries the clamped parameters (Q1.16, 65536 is one)
// and the two closest points, saturated to the coordinate range.
// cfg_ch writes the 32-bit epsilon register; write it only while the unit is
// empty. cfg_ch is always ready.
// Each word passes 27 register stages: three of dot products, two of split
// wide multiplies, three of determinant and clamping, one of divide setup,
// sixteen of the restoring divide (one quotient bit per stage) and two for
// the points. Throughput is one word per cycle while out_ch does not stall.
// Each stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so bubbles close up and a word waiting on out_ch
// does not stop new words from entering until the pipeline is full.
// Reset clears all valid bits and sets epsilon to 1.
// When the receiver stalls, the result holds and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_segment_closest_points_unit (
  input  logic         clk,
  input  logic         rst_n,
  ssc_in_if.sink       in_ch,
  ssc_out_if.source    out_ch,
  ssc_cfg_if.sink      cfg_ch
);

  localparam int NST = ssc_pkg::NST;

  logic [NST-1:0]          v_r;
  logic [NST:0]            en;
  logic [ssc_pkg::EW-1:0]  eps_r;
  ssc_pkg::side_t          side_r [ssc_pkg::ST_PNT];
  ssc_pkg::side_t          side_in;
  ssc_pkg::dots_t          dots;
  ssc_pkg::ratio_t         rat;
  ssc_pkg::frac_t          s_q, t_q;

  always_comb begin
    en[NST] = out_ch.ready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ch.ready  = en[0];
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      eps_r <= ssc_pkg::EW'(1);
    end else begin
      if (cfg_ch.valid) eps_r <= cfg_ch.data;
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign side_in.p0.x = in_ch.data.first_start_x;
  assign side_in.p0.y = in_ch.data.first_start_y;
  assign side_in.p0.z = in_ch.data.first_start_z;
  assign side_in.q0.x = in_ch.data.second_start_x;
  assign side_in.q0.y = in_ch.data.second_start_y;
  assign side_in.q0.z = in_ch.data.second_start_z;
  assign side_in.u.x  = ssc_pkg::DW'(in_ch.data.first_end_x) -
                        ssc_pkg::DW'(in_ch.data.first_start_x);
  assign side_in.u.y  = ssc_pkg::DW'(in_ch.data.first_end_y) -
                        ssc_pkg::DW'(in_ch.data.first_start_y);
  assign side_in.u.z  = ssc_pkg::DW'(in_ch.data.first_end_z) -
                        ssc_pkg::DW'(in_ch.data.first_start_z);
  assign side_in.v.x  = ssc_pkg::DW'(in_ch.data.second_end_x) -
                        ssc_pkg::DW'(in_ch.data.second_start_x);
  assign side_in.v.y  = ssc_pkg::DW'(in_ch.data.second_end_y) -
                        ssc_pkg::DW'(in_ch.data.second_start_y);
  assign side_in.v.z  = ssc_pkg::DW'(in_ch.data.second_end_z) -
                        ssc_pkg::DW'(in_ch.data.second_start_z);

  // Start points and directions ride along until the point stages.
  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_in;
    for (int i = 1; i < ssc_pkg::ST_PNT; i++) begin
      if (en[i]) side_r[i] <= side_r[i-1];
    end
  end

  ssc_front u_front (
    .clk  (clk),
    .en   (en[ssc_pkg::ST_CLAMP-1:0]),
    .din  (in_ch.data),
    .dots (dots)
  );

  ssc_clamp u_clamp (
    .clk  (clk),
    .en   (en[ssc_pkg::ST_DIV-1:ssc_pkg::ST_CLAMP]),
    .dots (dots),
    .eps  (eps_r),
    .rat  (rat)
  );

  ssc_div u_div_s (
    .clk (clk),
    .en  (en[ssc_pkg::ST_PNT-1:ssc_pkg::ST_DIV]),
    .eps (eps_r),
    .n   (rat.sn),
    .dn  (rat.sd),
    .q   (s_q)
  );

  ssc_div u_div_t (
    .clk (clk),
    .en  (en[ssc_pkg::ST_PNT-1:ssc_pkg::ST_DIV]),
    .eps (eps_r),
    .n   (rat.tn),
    .dn  (rat.td),
    .q   (t_q)
  );

  ssc_point u_point (
    .clk  (clk),
    .en   (en[NST-1:ssc_pkg::ST_PNT]),
    .side (side_r[ssc_pkg::ST_PNT-1]),
    .s    (s_q),
    .t    (t_q),
    .dout (out_ch.data)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted word did not enter the first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !en[1]) |-> !in_ch.ready)
    else $error("input taken while the first stage is blocked");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("stalled result changed or vanished");

  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.param_first <= ssc_pkg::PARAM_ONE &&
                      out_ch.data.param_second <= ssc_pkg::PARAM_ONE))
    else $error("parameter above one");

endmodule

/* hw/rtl/ssc_front.sv */
// ----------------------------------------------------------------------------
// ssc_front
// Three stages: direction vectors, coordinate products, dot products.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  ssc_pkg::in_t         din,
  output ssc_pkg::dots_t       dots
);

  logic signed [ssc_pkg::CW-1:0] a0 [3];
  logic signed [ssc_pkg::CW-1:0] a1 [3];
  logic signed [ssc_pkg::CW-1:0] b0 [3];
  logic signed [ssc_pkg::CW-1:0] b1 [3];
  logic signed [ssc_pkg::DW-1:0] u_r [3];
  logic signed [ssc_pkg::DW-1:0] v_r [3];
  logic signed [ssc_pkg::DW-1:0] w_r [3];
  logic signed [ssc_pkg::PW-1:0] prod_r [5][3];
  ssc_pkg::dots_t                dots_r;

  assign a0[0] = din.first_start_x;  assign a0[1] = din.first_start_y;
  assign a0[2] = din.first_start_z;
  assign a1[0] = din.first_end_x;    assign a1[1] = din.first_end_y;
  assign a1[2] = din.first_end_z;
  assign b0[0] = din.second_start_x; assign b0[1] = din.second_start_y;
  assign b0[2] = din.second_start_z;
  assign b1[0] = din.second_end_x;   assign b1[1] = din.second_end_y;
  assign b1[2] = din.second_end_z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (en[0]) begin
        u_r[i] <= ssc_pkg::DW'(a1[i]) - ssc_pkg::DW'(a0[i]);
        v_r[i] <= ssc_pkg::DW'(b1[i]) - ssc_pkg::DW'(b0[i]);
        w_r[i] <= ssc_pkg::DW'(a0[i]) - ssc_pkg::DW'(b0[i]);
      end
      if (en[1]) begin
        prod_r[0][i] <= u_r[i] * u_r[i];
        prod_r[1][i] <= u_r[i] * v_r[i];
        prod_r[2][i] <= v_r[i] * v_r[i];
        prod_r[3][i] <= u_r[i] * w_r[i];
        prod_r[4][i] <= v_r[i] * w_r[i];
      end
    end
    if (en[2]) begin
      dots_r.k <= ssc_pkg::SW'(prod_r[0][0]) + ssc_pkg::SW'(prod_r[0][1])
                + ssc_pkg::SW'(prod_r[0][2]);
      dots_r.j <= ssc_pkg::SW'(prod_r[1][0]) + ssc_pkg::SW'(prod_r[1][1])
                + ssc_pkg::SW'(prod_r[1][2]);
      dots_r.c <= ssc_pkg::SW'(prod_r[2][0]) + ssc_pkg::SW'(prod_r[2][1])
                + ssc_pkg::SW'(prod_r[2][2]);
      dots_r.d <= ssc_pkg::SW'(prod_r[3][0]) + ssc_pkg::SW'(prod_r[3][1])
                + ssc_pkg::SW'(prod_r[3][2]);
      dots_r.e <= ssc_pkg::SW'(prod_r[4][0]) + ssc_pkg::SW'(prod_r[4][1])
                + ssc_pkg::SW'(prod_r[4][2]);
    end
  end

  assign dots = dots_r;

endmodule

/* hw/rtl/ssc_wmul.sv */
// ----------------------------------------------------------------------------
// ssc_wmul
// Two-stage signed multiply of two dot products from four partial products.
// ----------------------------------------------------------------------------
module ssc_wmul (
  input  logic                          clk,
  input  logic [1:0]                    en,
  input  logic signed [ssc_pkg::SW-1:0] a,
  input  logic signed [ssc_pkg::SW-1:0] b,
  output logic signed [ssc_pkg::MW-1:0] p
);

  localparam int H  = ssc_pkg::HW;
  localparam int MW = ssc_pkg::MW;

  logic signed [ssc_pkg::SW-H-1:0] ah, bh;
  logic        [H-1:0]             al, bl;
  logic signed [2*H-1:0]           hh_r;
  logic signed [2*H:0]             hl_r, lh_r;
  logic        [2*H-1:0]           ll_r;
  logic signed [MW-1:0]            p_r;

  assign ah = a[ssc_pkg::SW-1:H];
  assign bh = b[ssc_pkg::SW-1:H];
  assign al = a[H-1:0];
  assign bl = b[H-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hh_r <= ah * bh;
      hl_r <= ah * $signed({1'b0, bl});
      lh_r <= $signed({1'b0, al}) * bh;
      ll_r <= al * bl;
    end
    if (en[1]) begin
      p_r <= (MW'(hh_r) <<< (2 * H)) + (MW'(hl_r) <<< H) + (MW'(lh_r) <<< H)
           + $signed(MW'(ll_r));
    end
  end

  assign p = p_r;

endmodule

/* hw/rtl/ssc_clamp.sv */
// ----------------------------------------------------------------------------
// ssc_clamp
// Determinant and numerators, then the two rounds of edge clamping.
// ----------------------------------------------------------------------------
module ssc_clamp (
  input  logic                     clk,
  input  logic [4:0]               en,
  input  ssc_pkg::dots_t           dots,
  input  logic [ssc_pkg::EW-1:0]   eps,
  output ssc_pkg::ratio_t          rat
);

  localparam int NW = ssc_pkg::NW;

  logic signed [ssc_pkg::MW-1:0] p_kc, p_jj, p_je, p_cd, p_ke, p_jd;
  ssc_pkg::dots_t dots3_r, dots4_r, dots5_r;
  ssc_pkg::wide_t dd5_r, sn5_r, tn5_r;
  ssc_pkg::ratio_t r6_nxt, r6_r, r7_nxt, r7_r;
  ssc_pkg::wide_t k6_r, j6_r, d6_r;
  ssc_pkg::wide_t eps_w;

  ssc_wmul u_kc (.clk(clk), .en(en[1:0]), .a(dots.k), .b(dots.c), .p(p_kc));
  ssc_wmul u_jj (.clk(clk), .en(en[1:0]), .a(dots.j), .b(dots.j), .p(p_jj));
  ssc_wmul u_je (.clk(clk), .en(en[1:0]), .a(dots.j), .b(dots.e), .p(p_je));
  ssc_wmul u_cd (.clk(clk), .en(en[1:0]), .a(dots.c), .b(dots.d), .p(p_cd));
  ssc_wmul u_ke (.clk(clk), .en(en[1:0]), .a(dots.k), .b(dots.e), .p(p_ke));
  ssc_wmul u_jd (.clk(clk), .en(en[1:0]), .a(dots.j), .b(dots.d), .p(p_jd));

  assign eps_w = $signed(NW'(eps));

  // First round: near-parallel test and clamping of the first parameter.
  always_comb begin
    r6_nxt.sn = sn5_r;
    r6_nxt.sd = dd5_r;
    r6_nxt.tn = tn5_r;
    r6_nxt.td = dd5_r;
    if (dd5_r < eps_w) begin
      r6_nxt.sn = '0;
      r6_nxt.sd = NW'(1);
      r6_nxt.tn = NW'(dots5_r.e);
      r6_nxt.td = NW'(dots5_r.c);
    end else if (sn5_r < 0) begin
      r6_nxt.sn = '0;
      r6_nxt.tn = NW'(dots5_r.e);
      r6_nxt.td = NW'(dots5_r.c);
    end else if (dd5_r < sn5_r) begin
      r6_nxt.sn = dd5_r;
      r6_nxt.tn = NW'(dots5_r.e) + NW'(dots5_r.j);
      r6_nxt.td = NW'(dots5_r.c);
    end
  end

  // Second round: clamp the second parameter and redo the first on that edge.
  always_comb begin
    ssc_pkg::wide_t num;
    logic           redo;
    r7_nxt = r6_r;
    num    = -d6_r;
    redo   = 1'b0;
    if (r6_r.tn < 0) begin
      r7_nxt.tn = '0;
      redo      = 1'b1;
    end else if (r6_r.td < r6_r.tn) begin
      r7_nxt.tn = r6_r.td;
      num       = j6_r - d6_r;
      redo      = 1'b1;
    end
    if (redo) begin
      if (num < 0) begin
        r7_nxt.sn = '0;
      end else if (k6_r < num) begin
        r7_nxt.sn = r6_r.sd;
      end else begin
        r7_nxt.sn = num;
        r7_nxt.sd = k6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) dots3_r <= dots;
    if (en[1]) dots4_r <= dots3_r;
    if (en[2]) begin
      dots5_r <= dots4_r;
      dd5_r   <= NW'(p_kc) - NW'(p_jj);
      sn5_r   <= NW'(p_je) - NW'(p_cd);
      tn5_r   <= NW'(p_ke) - NW'(p_jd);
    end
    if (en[3]) begin
      r6_r <= r6_nxt;
      k6_r <= NW'(dots5_r.k);
      j6_r <= NW'(dots5_r.j);
      d6_r <= NW'(dots5_r.d);
    end
    if (en[4]) r7_r <= r7_nxt;
  end

  assign rat = r7_r;

endmodule

/* hw/rtl/ssc_div.sv */
// ----------------------------------------------------------------------------
// ssc_div
// One parameter lane: special cases, then a restoring divide, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module ssc_div (
  input  logic                     clk,
  input  logic [ssc_pkg::QW:0]     en,
  input  logic [ssc_pkg::EW-1:0]   eps,
  input  ssc_pkg::wide_t           n,
  input  ssc_pkg::wide_t           dn,
  output ssc_pkg::frac_t           q
);

  localparam int QW = ssc_pkg::QW;
  localparam int RW = ssc_pkg::RW;
  localparam int NW = ssc_pkg::NW;

  logic [RW-1:0]  rem_r  [QW+1];
  logic [RW-1:0]  den_r  [QW+1];
  logic [QW-1:0]  quo_r  [QW+1];
  logic           zero_r [QW+1];
  logic           one_r  [QW+1];
  ssc_pkg::wide_t absn;
  logic           zero_nxt;

  assign absn     = (n < 0) ? -n : n;
  assign zero_nxt = ($unsigned(absn) < NW'(eps)) || (dn <= 0) || (n <= 0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= RW'($unsigned(n));
      den_r[0]  <= RW'($unsigned(dn));
      quo_r[0]  <= '0;
      zero_r[0] <= zero_nxt;
      one_r[0]  <= !zero_nxt && (n >= dn);
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [RW-1:0] rem2;
    logic          ge;
    assign rem2 = {rem_r[s-1][RW-2:0], 1'b0};
    assign ge   = rem2 >= den_r[s-1];
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= ge ? rem2 - den_r[s-1] : rem2;
        den_r[s]  <= den_r[s-1];
        quo_r[s]  <= {quo_r[s-1][QW-2:0], ge};
        zero_r[s] <= zero_r[s-1];
        one_r[s]  <= one_r[s-1];
      end
    end
  end

  assign q = zero_r[QW] ? '0 : one_r[QW] ? ssc_pkg::PARAM_ONE : {1'b0, quo_r[QW]};

endmodule

/* hw/rtl/ssc_point.sv */
// ----------------------------------------------------------------------------
// ssc_point
// Closest points: scale each direction by its parameter, round, saturate.
// ----------------------------------------------------------------------------
module ssc_point (
  input  logic             clk,
  input  logic [1:0]       en,
  input  ssc_pkg::side_t   side,
  input  ssc_pkg::frac_t   s,
  input  ssc_pkg::frac_t   t,
  output ssc_pkg::out_t    dout
);

  localparam int PRW  = ssc_pkg::PRW;
  localparam int SUMW = ssc_pkg::SUMW;
  localparam int QW   = ssc_pkg::QW;
  localparam logic signed [SUMW-1:0] SAT_HI =
    SUMW'((64'sd1 <<< (ssc_pkg::CW - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  logic signed [ssc_pkg::CW-1:0] start [6];
  logic signed [ssc_pkg::DW-1:0] diff  [6];
  logic signed [ssc_pkg::CW-1:0] start_r [6];
  logic signed [PRW-1:0]         prod_r  [6];
  logic signed [ssc_pkg::CW-1:0] res     [6];
  ssc_pkg::frac_t                s_r, t_r;
  ssc_pkg::out_t                 dout_r;

  assign start[0] = side.p0.x; assign start[1] = side.p0.y; assign start[2] = side.p0.z;
  assign start[3] = side.q0.x; assign start[4] = side.q0.y; assign start[5] = side.q0.z;
  assign diff[0]  = side.u.x;  assign diff[1]  = side.u.y;  assign diff[2]  = side.u.z;
  assign diff[3]  = side.v.x;  assign diff[4]  = side.v.y;  assign diff[5]  = side.v.z;

  for (genvar i = 0; i < 6; i++) begin : g_axis
    logic signed [PRW-1:0]  rnd;
    logic signed [SUMW-1:0] sum;
    assign rnd = prod_r[i] + PRW'(ssc_pkg::ROUND_HALF);
    // Arithmetic shift of the rounded product gives the floor.
    assign sum = SUMW'(start_r[i]) + SUMW'($signed(rnd[PRW-1:QW]));
    assign res[i] = (sum > SAT_HI) ? ssc_pkg::CW'(SAT_HI) :
                    (sum < SAT_LO) ? ssc_pkg::CW'(SAT_LO) : ssc_pkg::CW'(sum);
    always_ff @(posedge clk) begin
      if (en[0]) begin
        start_r[i] <= start[i];
        prod_r[i]  <= diff[i] * $signed({1'b0, (i < 3) ? s : t});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r <= s;
      t_r <= t;
    end
    if (en[1]) begin
      dout_r.param_first   <= s_r;
      dout_r.param_second  <= t_r;
      dout_r.near_first_x  <= res[0];
      dout_r.near_first_y  <= res[1];
      dout_r.near_first_z  <= res[2];
      dout_r.near_second_x <= res[3];
      dout_r.near_second_y <= res[4];
      dout_r.near_second_z <= res[5];
    end
  end

  assign dout = dout_r;

endmodule

/* verif/ssc_checker.sv */
// ----------------------------------------------------------------------------
// ssc_checker
// Watches the channels of the closest-points unit, predicts every result
// word from the accepted input word and the epsilon value in force, and
// compares each result word field by field in order.
// ----------------------------------------------------------------------------
module ssc_checker (
  input  logic      clk,
  input  logic      rst_n,
  ssc_in_if         in_ch,
  ssc_out_if        out_ch,
  ssc_cfg_if        cfg_ch,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] big_t;

  logic [ssc_pkg::EW-1:0] eps_q;
  ssc_pkg::out_t          expected_q[$];

  function automatic big_t dot3(longint a[3], longint b[3]);
    big_t s;
    s = 0;
    for (int i = 0; i < 3; i++) s += big_t'(a[i] * b[i]);
    return s;
  endfunction

  function automatic ssc_pkg::frac_t quotient(big_t n, big_t dn, big_t eps);
    big_t an;
    an = (n < 0) ? -n : n;
    if (an < eps) return '0;
    if (dn <= 0 || n <= 0) return '0;
    if (n >= dn) return ssc_pkg::PARAM_ONE;
    return ssc_pkg::frac_t'((n <<< ssc_pkg::QW) / dn);
  endfunction

  function automatic ssc_pkg::coord_t along(longint start, longint diff,
                                            ssc_pkg::frac_t t);
    longint p, v;
    p = diff * longint'(t) + 32768;
    v = start + (p >>> 16);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return ssc_pkg::coord_t'(v);
  endfunction

  // Parameter on segment one once segment two is pinned to one of its ends.
  function automatic void pin_first(big_t num, big_t k, inout big_t sn, inout big_t sd);
    if (num < 0) sn = 0;
    else if (k < num) sn = sd;
    else begin
      sn = num;
      sd = k;
    end
  endfunction

  function automatic ssc_pkg::out_t closest_points(ssc_pkg::in_t w,
                                                   logic [ssc_pkg::EW-1:0] eps_raw);
    longint        p0[3], q0[3], u[3], v[3], dw[3];
    big_t          k, j, c, d, e, dd, sn, sd, tn, td, eps;
    ssc_pkg::out_t r;
    p0 = '{w.first_start_x, w.first_start_y, w.first_start_z};
    q0 = '{w.second_start_x, w.second_start_y, w.second_start_z};
    u  = '{longint'(w.first_end_x) - p0[0], longint'(w.first_end_y) - p0[1],
           longint'(w.first_end_z) - p0[2]};
    v  = '{longint'(w.second_end_x) - q0[0], longint'(w.second_end_y) - q0[1],
           longint'(w.second_end_z) - q0[2]};
    for (int i = 0; i < 3; i++) dw[i] = p0[i] - q0[i];
    k = dot3(u, u);
    j = dot3(u, v);
    c = dot3(v, v);
    d = dot3(u, dw);
    e = dot3(v, dw);
    dd = k * c - j * j;
    eps = big_t'({96'b0, eps_raw});
    if (dd < eps) begin
      sn = 0; sd = 1; tn = e; td = c;
    end else begin
      sd = dd; td = dd;
      sn = j * e - c * d;
      tn = k * e - j * d;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sd < sn) begin
        sn = sd; tn = e + j; td = c;
      end
    end
    if (tn < 0) begin
      tn = 0;
      pin_first(-d, k, sn, sd);
    end else if (td < tn) begin
      tn = td;
      pin_first(j - d, k, sn, sd);
    end
    r.param_first   = quotient(sn, sd, eps);
    r.param_second  = quotient(tn, td, eps);
    r.near_first_x  = along(p0[0], u[0], r.param_first);
    r.near_first_y  = along(p0[1], u[1], r.param_first);
    r.near_first_z  = along(p0[2], u[2], r.param_first);
    r.near_second_x = along(q0[0], v[0], r.param_second);
    r.near_second_y = along(q0[1], v[1], r.param_second);
    r.near_second_z = along(q0[2], v[2], r.param_second);
    return r;
  endfunction

  function automatic int field_ok(string name, longint exp_v, longint act_v);
    if (exp_v == act_v) return 0;
    $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    ssc_pkg::out_t exp_w, act_w;
    int            bad;
    if (!rst_n) begin
      eps_q <= 1;
      errors <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) eps_q <= cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        expected_q = {expected_q, closest_points(in_ch.data, eps_q)};
      if (out_ch.valid && out_ch.ready) begin
        act_w = out_ch.data;
        if (expected_q.size() == 0) begin
          $display("%0t ns: result word with nothing expected", $time);
          errors <= errors + 1;
        end else begin
          exp_w = expected_q.pop_front();
          bad = 0;
          bad += field_ok("param_first", exp_w.param_first, act_w.param_first);
          bad += field_ok("param_second", exp_w.param_second, act_w.param_second);
          bad += field_ok("near_first_x", exp_w.near_first_x, act_w.near_first_x);
          bad += field_ok("near_first_y", exp_w.near_first_y, act_w.near_first_y);
          bad += field_ok("near_first_z", exp_w.near_first_z, act_w.near_first_z);
          bad += field_ok("near_second_x", exp_w.near_second_x, act_w.near_second_x);
          bad += field_ok("near_second_y", exp_w.near_second_y, act_w.near_second_y);
          bad += field_ok("near_second_z", exp_w.near_second_z, act_w.near_second_z);
          if (bad != 0) errors <= errors + 1;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* verif/tb_segment_segment_closest_points_unit.sv */
// ----------------------------------------------------------------------------
// tb_segment_segment_closest_points_unit
// Drives segment pairs and epsilon settings into the closest-points unit.
// Directed pairs cover extreme, degenerate, parallel and crossing segments;
// random pairs mix full-range, small, parallel and degenerate shapes under
// several epsilon values, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_segment_segment_closest_points_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending, idle_cycles;
  bit   zero_gaps, hold_request;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();
  ssc_cfg_if cfg_ch ();

  segment_segment_closest_points_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  ssc_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    out_ch.ready = 0;
  end

  function automatic int draw_gap();
    return zero_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int gap;
      gap = draw_gap();
      if (hold_request) begin
        gap = 400;
        hold_request = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pair(ssc_pkg::in_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [ssc_pkg::EW-1:0] value);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
  endtask

  function automatic ssc_pkg::in_t make_pair(ssc_pkg::coord_t a[3], ssc_pkg::coord_t b[3],
                                             ssc_pkg::coord_t p[3], ssc_pkg::coord_t q[3]);
    ssc_pkg::in_t w;
    w.first_start_x = a[0]; w.first_start_y = a[1]; w.first_start_z = a[2];
    w.first_end_x = b[0]; w.first_end_y = b[1]; w.first_end_z = b[2];
    w.second_start_x = p[0]; w.second_start_y = p[1]; w.second_start_z = p[2];
    w.second_end_x = q[0]; w.second_end_y = q[1]; w.second_end_z = q[2];
    return w;
  endfunction

  function automatic ssc_pkg::coord_t small_coord(int span);
    return ssc_pkg::coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random pair: mostly structured shapes with random content.
  function automatic ssc_pkg::in_t random_pair();
    ssc_pkg::coord_t a[3], b[3], p[3], q[3];
    int              span, shape, scale;
    span = ($urandom_range(0, 3) == 0) ? 32767 : (1 << $urandom_range(2, 12));
    for (int i = 0; i < 3; i++) begin
      a[i] = small_coord(span); b[i] = small_coord(span);
      p[i] = small_coord(span); q[i] = small_coord(span);
    end
    shape = $urandom_range(0, 9);
    case (shape)
      0: begin
        return ssc_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom});
      end
      1: b = a;
      2: q = p;
      3, 4: begin
        // Second segment parallel to the first, possibly reversed or offset.
        scale = $urandom_range(0, 1) ? 1 : -1;
        for (int i = 0; i < 3; i++)
          q[i] = ssc_pkg::coord_t'(p[i] + scale * (b[i] - a[i]));
      end
      5: p = a;
      6: begin
        // Nearly parallel: copy direction and nudge one component.
        for (int i = 0; i < 3; i++) q[i] = ssc_pkg::coord_t'(p[i] + (b[i] - a[i]));
        q[$urandom_range(0, 2)] += ssc_pkg::coord_t'($urandom_range(1, 3));
      end
      default: ;
    endcase
    return make_pair(a, b, p, q);
  endfunction

  initial begin
    ssc_pkg::coord_t        zero3[3], hi3[3], lo3[3], ex[3], ey[3], ez[3], mx[3];
    logic [ssc_pkg::EW-1:0] eps_list[5];
    zero3 = '{0, 0, 0};
    hi3 = '{32767, 32767, 32767};
    lo3 = '{-32768, -32768, -32768};
    ex = '{256, 0, 0}; ey = '{0, 256, 0}; ez = '{0, 0, 256};
    mx = '{-256, 0, 0};
    eps_list = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd1, 32'd0};
    eps_list[2] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed words under the reset value of epsilon.
    send_pair(make_pair(zero3, zero3, zero3, zero3));
    send_pair(make_pair(hi3, hi3, lo3, lo3));
    send_pair(make_pair(lo3, hi3, hi3, lo3));
    send_pair(make_pair(lo3, hi3, lo3, hi3));
    send_pair(make_pair(hi3, lo3, zero3, ex));
    send_pair(make_pair(zero3, ex, ey, ez));
    send_pair(make_pair(mx, ex, ey, '{0, -256, 0}));
    send_pair(make_pair(zero3, ex, ey, '{256, 256, 0}));
    send_pair(make_pair(zero3, ex, '{512, 0, 0}, '{768, 0, 0}));
    send_pair(make_pair(zero3, ex, '{-512, 0, 0}, '{-256, 0, 0}));
    send_pair(make_pair(zero3, ex, ey, '{256, 256, 0}));
    send_pair(make_pair(zero3, ex, '{128, 0, 256}, '{128, 0, 512}));
    send_pair(make_pair(zero3, ex, '{-128, 256, 0}, '{-128, 512, 0}));
    send_pair(make_pair(ey, ey, zero3, ex));
    send_pair(make_pair(zero3, ex, ez, ez));
    send_pair(make_pair(zero3, hi3, '{1, 0, 0}, '{32767, 32767, 32766}));
    send_pair(make_pair(lo3, hi3, '{32767, -32768, 0}, '{-32768, 32767, 0}));
    send_pair(make_pair('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 1, 1}));

    foreach (eps_list[n]) begin
      write_epsilon(eps_list[n]);
      send_pair(make_pair(zero3, ex, ey, '{256, 256, 0}));
      send_pair(make_pair('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{1, 1, 1}));
      for (int i = 0; i < 285; i++) begin
        if (i % 60 == 0) zero_gaps = ($urandom_range(0, 2) == 0);
        if (n == 1 && i == 100) hold_request = 1;
        if (n == 2 && i == 150) begin
          // Let everything in flight come out before going on.
          in_ch.valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_pair(random_pair());
      end
    end
    zero_gaps = 0;

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_in_if.sv
hw/rtl/ssc_out_if.sv
hw/rtl/ssc_cfg_if.sv
hw/rtl/ssc_front.sv
hw/rtl/ssc_wmul.sv
hw/rtl/ssc_clamp.sv
hw/rtl/ssc_div.sv
hw/rtl/ssc_point.sv
hw/rtl/segment_segment_closest_points_unit.sv
verif/ssc_checker.sv
verif/tb_segment_segment_closest_points_unit.sv
